[rtl/swmf_pkg.sv]
// shared types and constants for the sliding window median filter
// no dependencies; imported by the cell and the top level

package swmf_pkg;

    // smallest window that gives results
    localparam int MIN_WINDOW = 3;

    // width of the window size register
    localparam int CFG_WIDTH = 4;

    // per-cycle control broadcast to every cell of the window chain
    typedef struct packed {
        logic shift;  // load the value of the left neighbor
        logic clear;  // zero the rank counter
        logic count;  // compare against the probe and count
    } t_cell_ctrl;

endpackage

[rtl/swmf_cell.sv]
// one cell of the window chain: holds one sample and its rank counter
// depends on swmf_pkg for the control struct

module swmf_cell
    import swmf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int IDX_W        = 4,
    parameter int RANK_W       = 4,
    parameter int IDX          = 0
) (
    input  logic                           i_clk,
    input  t_cell_ctrl                     i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_shift_in,
    input  logic signed [SAMPLE_WIDTH-1:0] i_probe,
    input  logic        [IDX_W-1:0]        i_probe_idx,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output logic        [RANK_W-1:0]       o_rank
);

    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic        [RANK_W-1:0]       r_rank;
    logic                           w_below;

    // probe ranks below this cell; ties broken by position so ranks stay unique
    assign w_below = (i_probe < r_value) ||
                     ((i_probe == r_value) && (i_probe_idx < IDX_W'(IDX)));

    // sample register, part of the window shift chain
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_value <= i_shift_in;
        end
    end

    // rank counter
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_rank <= '0;
        end else if (i_ctrl.count && w_below) begin
            r_rank <= r_rank + RANK_W'(1);
        end
    end

    assign o_value = r_value;
    assign o_rank  = r_rank;

endmodule

[rtl/sliding_window_median_filter_core.sv]
// Running median filter over an odd window of 3 to MAX_WINDOW samples.
// Slave stream takes one sample per request: tdata holds the sample, tuser
// the restart flag (1 clears the window; this sample becomes its first entry).
// Master stream gives the median of the last win_len samples in tdata.
// The config channel (i_cfg_valid/o_cfg_ready/i_cfg_data) writes win_len,
// the window length; write it only while the block is idle. Even lengths,
// lengths below 3 and lengths above MAX_WINDOW give no results. The first
// win_len-1 samples after a restart give no result.
// Each sample shifts into a chain of cells. A result then takes a rank
// pass, in which each window entry in turn is broadcast to all cells, and
// then a select step that registers the median; a new sample is taken only
// once the block is back in idle. A sample that gives no result leaves the
// block idle, ready for the next sample.
// The result sits in an output register, so the next sample is taken while
// it waits; if the receiver still stalls when the next median is ready, the
// block holds in its select state until the output register frees.
// Reset (synchronous, active low) empties the window, drops any result and
// sets win_len to 3.
// depends on swmf_pkg and swmf_cell

module sliding_window_median_filter_core
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW   = 15,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_WIDTH-1:0] i_cfg_data,     // window length
    // slave stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] i_s_axis_tdata, // sample, then zero pad
    input  logic                 i_s_axis_tuser, // restart
    // master stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] o_m_axis_tdata  // median, then zero pad
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int RANK_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (RANK_W > CFG_WIDTH) ? RANK_W : CFG_WIDTH;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]                     r_state, n_state;
    logic [CFG_WIDTH-1:0]           r_wsize;
    logic [RANK_W-1:0]              r_fill, n_fill;
    logic [IDX_W-1:0]               r_k, n_k;
    logic                           r_out_valid, n_out_valid;
    logic [SAMPLE_WIDTH-1:0]        r_out_data, n_out_data;

    t_cell_ctrl                     w_ctrl;
    logic signed [SAMPLE_WIDTH-1:0] w_sample;
    logic signed [SAMPLE_WIDTH-1:0] w_probe;
    logic signed [SAMPLE_WIDTH-1:0] w_value [MAX_WINDOW];
    logic        [RANK_W-1:0]       w_rank  [MAX_WINDOW];
    logic [CMP_W-1:0]               w_wsize_ext;
    logic [CMP_W-1:0]               w_half;
    logic                           w_in_req;
    logic                           w_out_free;
    logic                           w_produce;
    logic [SAMPLE_WIDTH-1:0]        w_median;

    assign w_sample    = i_s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign w_wsize_ext = CMP_W'(r_wsize);
    assign w_half      = w_wsize_ext >> 1;
    assign w_in_req    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free  = !r_out_valid || i_m_axis_tready;

    // fill count after this request: 1 on a restart, else saturating at the chain depth
    always_comb begin
        if (i_s_axis_tuser) begin
            n_fill = RANK_W'(1);
        end else if (r_fill == RANK_W'(MAX_WINDOW)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + RANK_W'(1);
        end
    end

    // a median is due when the size is a usable odd value and the window is full
    assign w_produce = r_wsize[0] &&
                       (w_wsize_ext >= CMP_W'(MIN_WINDOW)) &&
                       (w_wsize_ext <= CMP_W'(MAX_WINDOW)) &&
                       (CMP_W'(n_fill) >= w_wsize_ext);

    // broadcast one window entry per rank cycle
    assign w_probe = w_value[r_k];

    // window chain
    for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
        logic signed [SAMPLE_WIDTH-1:0] w_left;
        if (gi == 0) begin : g_head
            assign w_left = w_sample;
        end else begin : g_body
            assign w_left = w_value[gi-1];
        end
        swmf_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .IDX_W        (IDX_W),
            .RANK_W       (RANK_W),
            .IDX          (gi)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_shift_in  (w_left),
            .i_probe     (w_probe),
            .i_probe_idx (r_k),
            .o_value     (w_value[gi]),
            .o_rank      (w_rank[gi])
        );
    end

    // pick the active cell whose rank is the middle one
    always_comb begin
        w_median = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if ((CMP_W'(i) < w_wsize_ext) && (CMP_W'(w_rank[i]) == w_half)) begin
                w_median = w_median | w_value[i];
            end
        end
    end

    // sequencer: take sample, rank pass, select
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_ctrl      = '0;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_req) begin
                    w_ctrl.shift = 1'b1;
                    w_ctrl.clear = 1'b1;
                    n_k          = '0;
                    if (w_produce) begin
                        n_state = ST_COUNT;
                    end
                end
            end
            ST_COUNT: begin
                w_ctrl.count = 1'b1;
                n_k          = r_k + IDX_W'(1);
                if (CMP_W'(r_k) == w_wsize_ext - CMP_W'(1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_median;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_wsize     <= CFG_WIDTH'(MIN_WINDOW);
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (w_in_req) begin
                r_fill <= n_fill;
            end
            if (i_cfg_valid) begin
                r_wsize <= i_cfg_data;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'(r_out_data);

endmodule

[rtl/swmf_checker.sv]
// port-level checks for the sliding window median filter core
// needs the core's port list and its TDATA_W; bound to sliding_window_median_filter_core below

module swmf_checker #(
    parameter int TDATA_W = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [TDATA_W-1:0]   o_m_axis_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // reset drops any pending result
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered right after reset");

    // a median needs the rank pass, so none shows up right after a sample request
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !$rose(o_m_axis_tvalid))
        else $error("result appeared without a rank pass");

endmodule

bind sliding_window_median_filter_core swmf_checker #(
    .TDATA_W (TDATA_W)
) u_swmf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
